>>> rtl/ptpr_pkg.sv
package ptpr_pkg;

    // store geometry
    localparam int DEF_VIDEO_STORE_BYTES = 65536;
    localparam int PALETTE_STORE_BYTES   = 512;
    localparam int PALETTE_HALF          = PALETTE_STORE_BYTES / 2;
    localparam int NUM_PLANES            = 8;
    localparam int NUM_BANKS             = 8;

    // request commands
    localparam logic [1:0] CMD_VIDEO_WRITE   = 2'd0;
    localparam logic [1:0] CMD_PALETTE_WRITE = 2'd1;
    localparam logic [1:0] CMD_PLOT          = 2'd2;

    // register indexes
    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] REG_FLIP_MODE    = 3'd2;
    localparam logic [2:0] REG_BPP          = 3'd3;
    localparam logic [2:0] REG_PALETTE_BASE = 3'd4;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd5;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd6;
    localparam logic [2:0] REG_TILE_BASE    = 3'd7;

    // supported bit depths
    localparam logic [3:0] BPP_2 = 4'd2;
    localparam logic [3:0] BPP_4 = 4'd4;
    localparam logic [3:0] BPP_8 = 4'd8;

    // register reset values
    localparam logic [3:0]  RST_BPP          = 4'd4;
    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd8;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd8;

    // byte offset of each bitplane from the row address
    localparam logic [5:0] PLANE_OFFS [NUM_PLANES] = '{
        6'd0, 6'd1, 6'd16, 6'd17, 6'd32, 6'd33, 6'd48, 6'd49
    };

    // video store write request
    typedef struct packed {
        logic        en;
        logic [15:0] addr;
        logic [7:0]  data;
    } vid_wr_t;

    // palette store write request
    typedef struct packed {
        logic       en;
        logic [8:0] addr;
        logic [7:0] data;
    } pal_wr_t;

endpackage

>>> rtl/ptpr_video_banks.sv
// eight byte banks, bank = {addr[5:4], addr[0]}: a row's eight plane bytes always
// sit in eight banks, one each; user keeps VIDEO_STORE_BYTES a power of 2, unchecked
module ptpr_video_banks
    import ptpr_pkg::*;
#(
    parameter int VIDEO_STORE_BYTES = DEF_VIDEO_STORE_BYTES
)
(
    input  logic                           clk,
    input  vid_wr_t                        wr,
    input  logic                           rd_en,
    input  logic [15:0]                    row_addr,
    output logic [NUM_PLANES-1:0][7:0]     plane_bytes
);

    localparam int ADDR_W     = $clog2(VIDEO_STORE_BYTES);
    localparam int IDX_W      = ADDR_W - 3;
    localparam int BANK_DEPTH = VIDEO_STORE_BYTES / NUM_BANKS;

    logic [ADDR_W-1:0] plane_addr [NUM_PLANES];
    logic [2:0]        plane_bank [NUM_PLANES];
    logic [IDX_W-1:0]  plane_idx  [NUM_PLANES];
    logic [IDX_W-1:0]  bank_idx   [NUM_BANKS];
    logic [7:0]        bank_data  [NUM_BANKS];
    logic [2:0]        bank_sel_reg [NUM_PLANES];
    logic [ADDR_W-1:0] wr_addr;
    logic [2:0]        wr_bank;
    logic [IDX_W-1:0]  wr_idx;

    // plane addresses and their bank placement
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            plane_addr[p] = ADDR_W'(row_addr + {10'd0, PLANE_OFFS[p]});
            plane_bank[p] = {plane_addr[p][5:4], plane_addr[p][0]};
            plane_idx[p]  = {plane_addr[p][ADDR_W-1:6], plane_addr[p][3:1]};
        end
    end

    // route each plane address to its bank
    always_comb
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            bank_idx[b] = '0;
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                if (plane_bank[p] == 3'(b))
                begin
                    bank_idx[b] = bank_idx[b] | plane_idx[p];
                end
            end
        end
    end

    // write address split
    assign wr_addr = wr.addr[ADDR_W-1:0];
    assign wr_bank = {wr_addr[5:4], wr_addr[0]};
    assign wr_idx  = {wr_addr[ADDR_W-1:6], wr_addr[3:1]};

    // banks, one write and one registered read each
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        logic [7:0] bank_mem [BANK_DEPTH];
        logic [7:0] rd_data_reg;

        always_ff @(posedge clk)
        begin
            if (wr.en && (wr_bank == 3'(b)))
            begin
                bank_mem[wr_idx] <= wr.data;
            end
            if (rd_en)
            begin
                rd_data_reg <= bank_mem[bank_idx[b]];
            end
        end

        assign bank_data[b] = rd_data_reg;
    end

    // remember which bank holds each plane
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                bank_sel_reg[p] <= plane_bank[p];
            end
        end
    end

    // bring bank data back into plane order
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            plane_bytes[p] = bank_data[bank_sel_reg[p]];
        end
    end

endmodule

>>> rtl/ptpr_palette.sv
// palette split into even and odd byte halves so both color bytes read at once
module ptpr_palette
    import ptpr_pkg::*;
(
    input  logic        clk,
    input  pal_wr_t     wr,
    input  logic        rd_en,
    input  logic [7:0]  rd_index,
    output logic [15:0] color
);

    logic [7:0]  even_mem [PALETTE_HALF];
    logic [7:0]  odd_mem  [PALETTE_HALF];
    logic [15:0] color_reg;

    // byte writes and little-endian color read
    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.addr[0])
        begin
            even_mem[wr.addr[8:1]] <= wr.data;
        end
        if (wr.en && wr.addr[0])
        begin
            odd_mem[wr.addr[8:1]] <= wr.data;
        end
        if (rd_en)
        begin
            color_reg <= {odd_mem[rd_index], even_mem[rd_index]};
        end
    end

    assign color = color_reg;

endmodule

>>> rtl/planar_tile_pixel_renderer_unit.sv
// path: an accepted request moves through the stage registers and the output register to m_tvalid
// throughput: one request per clock unless the pipe stalls; each video bank and palette half
// has one read port per cycle, and the eight plane bytes of a row always sit in eight different banks
// stalls: the whole pipe holds only while a finished pixel waits and another pixel is right behind it
// reset: control state and registers return to their defaults; stores are not cleared
module planar_tile_pixel_renderer_unit
    import ptpr_pkg::*;
#(
    parameter int VIDEO_STORE_BYTES = DEF_VIDEO_STORE_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // address, data_byte, local_x, local_y, zero pad
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // screen_x, screen_y, pixel_color
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [8:0]  origin_x_reg;
    logic [7:0]  origin_y_reg;
    logic [1:0]  flip_mode_reg;
    logic [3:0]  bpp_reg;
    logic [7:0]  palette_base_reg;
    logic [10:0] image_width_reg;
    logic [10:0] image_height_reg;
    logic [15:0] tile_base_reg;

    // pipe control
    logic adv;
    logic load_out;

    // stage 1
    logic [9:0]  in_x;
    logic [9:0]  in_y;
    logic        in_range;
    logic [8:0]  sx_sum;
    logic [10:0] x_flip;
    logic [10:0] y_flip;
    logic        depth_ok;
    logic        s1_valid_reg;
    logic [1:0]  s1_cmd_reg;
    logic [15:0] s1_addr_reg;
    logic [7:0]  s1_data_reg;
    logic        s1_plot_reg;
    logic [7:0]  s1_sx_reg;
    logic [7:0]  s1_sy_reg;
    logic [9:0]  s1_x_reg;
    logic [9:0]  s1_y_reg;

    // stage 2
    logic [15:0] col_term;
    logic [15:0] row_term;
    logic [15:0] row_next;
    logic        s2_valid_reg;
    logic [1:0]  s2_cmd_reg;
    logic [15:0] s2_addr_reg;
    logic [7:0]  s2_data_reg;
    logic        s2_plot_reg;
    logic [7:0]  s2_sx_reg;
    logic [7:0]  s2_sy_reg;
    logic [15:0] s2_row_reg;
    logic [2:0]  s2_bitpos_reg;

    // stage 3
    vid_wr_t                     vid_wr;
    logic [NUM_PLANES-1:0][7:0]  plane_bytes;
    logic [NUM_PLANES-1:0]       plane_bits;
    logic [7:0]                  depth_mask;
    logic [7:0]                  col_index;
    logic                        s3_valid_reg;
    logic [1:0]                  s3_cmd_reg;
    logic [15:0]                 s3_addr_reg;
    logic [7:0]                  s3_data_reg;
    logic                        s3_plot_reg;
    logic [7:0]                  s3_sx_reg;
    logic [7:0]                  s3_sy_reg;
    logic [2:0]                  s3_bitpos_reg;

    // stage 4
    pal_wr_t     pal_wr;
    logic        s4_valid_reg;
    logic [1:0]  s4_cmd_reg;
    logic [15:0] s4_addr_reg;
    logic [7:0]  s4_data_reg;
    logic        s4_emit_reg;
    logic [7:0]  s4_sx_reg;
    logic [7:0]  s4_sy_reg;
    logic [7:0]  s4_pidx_reg;

    // output stage
    logic        out_valid_reg;
    logic [7:0]  out_sx_reg;
    logic [7:0]  out_sy_reg;
    logic [15:0] pixel_color;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            flip_mode_reg    <= '0;
            bpp_reg          <= RST_BPP;
            palette_base_reg <= '0;
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            tile_base_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg     <= cfg_data[8:0];
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_data[7:0];
                REG_FLIP_MODE:    flip_mode_reg    <= cfg_data[1:0];
                REG_BPP:          bpp_reg          <= cfg_data[3:0];
                REG_PALETTE_BASE: palette_base_reg <= cfg_data[7:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[10:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[10:0];
                REG_TILE_BASE:    tile_base_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // pipe moves unless a waiting pixel would be overwritten by another pixel
    assign load_out = !out_valid_reg || m_tready;
    assign adv      = load_out || !(s4_valid_reg && s4_emit_reg);
    assign s_tready = adv;

    // stage 1: bounds, screen position, flip, depth check
    assign in_x     = s_tdata[33:24];
    assign in_y     = s_tdata[43:34];
    assign in_range = ({1'b0, in_x} < image_width_reg) && ({1'b0, in_y} < image_height_reg);
    assign sx_sum   = origin_x_reg + in_x[8:0];
    assign x_flip   = image_width_reg - 11'd1 - {1'b0, in_x};
    assign y_flip   = image_height_reg - 11'd1 - {1'b0, in_y};
    assign depth_ok = (bpp_reg == BPP_2) || (bpp_reg == BPP_4) || (bpp_reg == BPP_8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg  <= s_tuser;
            s1_addr_reg <= s_tdata[15:0];
            s1_data_reg <= s_tdata[23:16];
            s1_plot_reg <= (s_tuser == CMD_PLOT) && in_range && !sx_sum[8] && depth_ok;
            s1_sx_reg   <= sx_sum[7:0];
            s1_sy_reg   <= origin_y_reg + in_y[7:0];
            s1_x_reg    <= flip_mode_reg[0] ? x_flip[9:0] : in_x;
            s1_y_reg    <= flip_mode_reg[1] ? y_flip[9:0] : in_y;
        end
    end

    // stage 2: row byte address of the tile row
    always_comb
    begin
        case (bpp_reg)
            BPP_2:
            begin
                col_term = {5'd0, s1_x_reg[9:3], 4'd0};
                row_term = {1'b0, s1_y_reg[9:3], 8'd0};
            end
            BPP_4:
            begin
                col_term = {4'd0, s1_x_reg[9:3], 5'd0};
                row_term = {s1_y_reg[9:3], 9'd0};
            end
            BPP_8:
            begin
                col_term = {3'd0, s1_x_reg[9:3], 6'd0};
                row_term = {s1_y_reg[8:3], 10'd0};
            end
            default:
            begin
                col_term = '0;
                row_term = '0;
            end
        endcase
        row_next = tile_base_reg + col_term + row_term + {12'd0, s1_y_reg[2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_cmd_reg    <= s1_cmd_reg;
            s2_addr_reg   <= s1_addr_reg;
            s2_data_reg   <= s1_data_reg;
            s2_plot_reg   <= s1_plot_reg;
            s2_sx_reg     <= s1_sx_reg;
            s2_sy_reg     <= s1_sy_reg;
            s2_row_reg    <= row_next;
            s2_bitpos_reg <= ~s1_x_reg[2:0];
        end
    end

    // stage 3: video bank access, writes in the same stage as reads keep order
    assign vid_wr.en   = adv && s2_valid_reg && (s2_cmd_reg == CMD_VIDEO_WRITE);
    assign vid_wr.addr = s2_addr_reg;
    assign vid_wr.data = s2_data_reg;

    ptpr_video_banks #(
        .VIDEO_STORE_BYTES (VIDEO_STORE_BYTES)
    ) u_video (
        .clk         (clk),
        .wr          (vid_wr),
        .rd_en       (adv),
        .row_addr    (s2_row_reg),
        .plane_bytes (plane_bytes)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_cmd_reg    <= s2_cmd_reg;
            s3_addr_reg   <= s2_addr_reg;
            s3_data_reg   <= s2_data_reg;
            s3_plot_reg   <= s2_plot_reg;
            s3_sx_reg     <= s2_sx_reg;
            s3_sy_reg     <= s2_sy_reg;
            s3_bitpos_reg <= s2_bitpos_reg;
        end
    end

    // gather plane bits into the color index
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            plane_bits[p] = plane_bytes[p][s3_bitpos_reg];
        end
        case (bpp_reg)
            BPP_2:   depth_mask = 8'h03;
            BPP_4:   depth_mask = 8'h0f;
            BPP_8:   depth_mask = 8'hff;
            default: depth_mask = 8'h00;
        endcase
        col_index = plane_bits & depth_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_cmd_reg  <= s3_cmd_reg;
            s4_addr_reg <= s3_addr_reg;
            s4_data_reg <= s3_data_reg;
            s4_emit_reg <= s3_plot_reg && (col_index != 8'd0);
            s4_sx_reg   <= s3_sx_reg;
            s4_sy_reg   <= s3_sy_reg;
            s4_pidx_reg <= col_index + palette_base_reg;
        end
    end

    // stage 4: palette access, color read lands in the output register
    assign pal_wr.en   = adv && s4_valid_reg && (s4_cmd_reg == CMD_PALETTE_WRITE);
    assign pal_wr.addr = s4_addr_reg[8:0];
    assign pal_wr.data = s4_data_reg;

    ptpr_palette u_palette (
        .clk      (clk),
        .wr       (pal_wr),
        .rd_en    (load_out),
        .rd_index (s4_pidx_reg),
        .color    (pixel_color)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= s4_valid_reg && s4_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_sx_reg <= s4_sx_reg;
            out_sy_reg <= s4_sy_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {pixel_color, out_sy_reg, out_sx_reg};

    // a pixel only comes from a plot request
    assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && s4_emit_reg) |-> (s4_cmd_reg == CMD_PLOT))
        else $error("pixel emitted by a non-plot request");

    // a plot flag only rides on a plot request
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_plot_reg) |-> (s1_cmd_reg == CMD_PLOT))
        else $error("plot flag on a non-plot request");

    // input held back only while a pixel waits on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("pipe stalled without a waiting pixel");

    // a pixel leaving stage 4 reaches the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && s4_emit_reg && adv) |=> m_tvalid)
        else $error("pixel lost between stage 4 and output");

    // a waiting pixel blocks the next pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && s4_valid_reg && s4_emit_reg) |-> !adv)
        else $error("waiting pixel overwritten");

endmodule

>>> dv/planar_tile_pixel_renderer_unit_tb.sv
`timescale 1ns / 100ps

module planar_tile_pixel_renderer_unit_tb;
    import ptpr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASES       = 9;
    localparam int PHASE_REQS   = 150;
    localparam int CALM_PHASE   = 4;

    // the one command code the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] color;
    } pixel_t;

    typedef struct packed {
        logic [8:0]  org_x;
        logic [7:0]  org_y;
        logic [1:0]  flip;
        logic [3:0]  bpp;
        logic [7:0]  pal_base;
        logic [10:0] width;
        logic [10:0] height;
        logic [15:0] tile_base;
    } regs_t;

    typedef enum logic [1:0] {STEP_REG, STEP_REQ} step_kind_t;
    typedef enum logic [1:0] {BY_MODEL, NO_PIXEL, PIXEL_AT} check_t;

    typedef struct packed {
        step_kind_t  kind;
        check_t      chk;
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [9:0]  lx;
        logic [9:0]  ly;
        pixel_t      want;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // mirror of the stores and registers
    logic [7:0] vid_mem [0:65535];
    bit         vid_known [0:65535];
    logic [7:0] pal_mem [0:511];
    bit         pal_known [0:511];
    regs_t      regs;

    pixel_t pending_pixels [$];
    int     errors;
    int     cycles;
    int     reqs_done;
    int     plots_done;
    int     writes_done;
    int     pixels_seen;
    int     reg_writes;
    bit     calm;

    planar_tile_pixel_renderer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels still pending",
                     cycles, pending_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // pixel sink back-pressure
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 23);
    end

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // compare each drawn pixel with the oldest pending one
    always @(posedge clk)
    begin : pixel_check
        pixel_t got;
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x     = m_tdata[7:0];
            got.y     = m_tdata[15:8];
            got.color = m_tdata[31:16];
            pixels_seen++;
            if (pending_pixels.size() == 0)
            begin
                report($sformatf("unexpected pixel x=%0d y=%0d color=%h",
                                 got.x, got.y, got.color));
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got.x !== want.x)
                    report($sformatf("screen_x %0d, want %0d", got.x, want.x));
                if (got.y !== want.y)
                    report($sformatf("screen_y %0d, want %0d", got.y, want.y));
                if (got.color !== want.color)
                    report($sformatf("pixel_color %h, want %h", got.color, want.color));
            end
        end
    end

    // random bits above a register's width, which the block must drop
    function automatic logic [15:0] reg_junk(input logic [2:0] idx);
        int w;
        case (idx)
            REG_ORIGIN_X:     w = 9;
            REG_ORIGIN_Y:     w = 8;
            REG_FLIP_MODE:    w = 2;
            REG_BPP:          w = 4;
            REG_PALETTE_BASE: w = 8;
            REG_IMAGE_WIDTH:  w = 11;
            REG_IMAGE_HEIGHT: w = 11;
            default:          w = 16;
        endcase
        return 16'($urandom) << w;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            REG_ORIGIN_X:     regs.org_x = val[8:0];
            REG_ORIGIN_Y:     regs.org_y = val[7:0];
            REG_FLIP_MODE:    regs.flip = val[1:0];
            REG_BPP:          regs.bpp = val[3:0];
            REG_PALETTE_BASE: regs.pal_base = val[7:0];
            REG_IMAGE_WIDTH:  regs.width = val[10:0];
            REG_IMAGE_HEIGHT: regs.height = val[10:0];
            REG_TILE_BASE:    regs.tile_base = val;
            default:          ;
        endcase
    endfunction

    // flip, screen position and row address; 0 when nothing is read
    function automatic bit find_row(input logic [9:0] lx, input logic [9:0] ly,
                                    output logic [15:0] row, output logic [2:0] bitpos,
                                    output int depth, output pixel_t px);
        int x;
        int y;
        int sx;
        int col_sh;
        int row_sh;
        px = '0;
        row = '0;
        bitpos = '0;
        depth = 0;
        if (lx >= regs.width || ly >= regs.height)
            return 0;
        sx = (int'(regs.org_x) + int'(lx)) % 512;
        if (sx >= 256)
            return 0;
        px.x = 8'(sx);
        px.y = 8'(int'(regs.org_y) + int'(ly));
        x = regs.flip[0] ? int'(regs.width) - 1 - int'(lx) : int'(lx);
        y = regs.flip[1] ? int'(regs.height) - 1 - int'(ly) : int'(ly);
        case (regs.bpp)
            BPP_2:
            begin
                depth = 2; col_sh = 4; row_sh = 8;
            end
            BPP_4:
            begin
                depth = 4; col_sh = 5; row_sh = 9;
            end
            BPP_8:
            begin
                depth = 8; col_sh = 6; row_sh = 10;
            end
            default:
                return 0;
        endcase
        row = 16'(int'(regs.tile_base) + ((x >> 3) << col_sh) + ((y >> 3) << row_sh)
                  + ((y & 7) << 1));
        bitpos = 3'(7 - (x & 7));
        return 1;
    endfunction

    // one bit from each plane byte
    function automatic logic [7:0] color_index(input logic [15:0] row,
                                               input logic [2:0] bitpos, input int depth);
        logic [7:0]  idx;
        logic [15:0] a;
        idx = '0;
        for (int p = 0; p < depth; p++)
        begin
            a = row + 16'(PLANE_OFFS[p]);
            idx[p] = vid_mem[a][bitpos];
        end
        return idx;
    endfunction

    // store update or drawn pixel for one request
    function automatic bit render_pixel(input logic [1:0] cmd, input logic [15:0] addr,
                                        input logic [7:0] data, input logic [9:0] lx,
                                        input logic [9:0] ly, output pixel_t px);
        logic [15:0] row;
        logic [2:0]  bitpos;
        int          depth;
        logic [7:0]  idx;
        logic [7:0]  c;
        px = '0;
        case (cmd)
            CMD_VIDEO_WRITE:
            begin
                vid_mem[addr] = data;
                vid_known[addr] = 1'b1;
            end
            CMD_PALETTE_WRITE:
            begin
                pal_mem[addr[8:0]] = data;
                pal_known[addr[8:0]] = 1'b1;
            end
            CMD_PLOT:
            begin
                if (find_row(lx, ly, row, bitpos, depth, px))
                begin
                    idx = color_index(row, bitpos, depth);
                    if (idx != 0)
                    begin
                        c = idx + regs.pal_base;
                        px.color = {pal_mem[{c, 1'b1}], pal_mem[{c, 1'b0}]};
                        return 1;
                    end
                end
            end
            default: ;
        endcase
        return 0;
    endfunction

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_reg(idx, val);
        reg_writes++;
    endtask

    // write any plane or palette byte a plot would read before it is set
    task automatic fill_for_plot(input logic [9:0] lx, input logic [9:0] ly);
        logic [15:0] row;
        logic [15:0] a;
        logic [2:0]  bitpos;
        int          depth;
        pixel_t      px;
        logic [7:0]  idx;
        logic [7:0]  c;
        logic [8:0]  pa;
        if (!find_row(lx, ly, row, bitpos, depth, px))
            return;
        for (int p = 0; p < depth; p++)
        begin
            a = row + 16'(PLANE_OFFS[p]);
            if (!vid_known[a])
                send_request(CMD_VIDEO_WRITE, a, 8'($urandom), 10'($urandom),
                             10'($urandom), BY_MODEL, '0);
        end
        idx = color_index(row, bitpos, depth);
        if (idx == 0)
            return;
        c = idx + regs.pal_base;
        for (int k = 0; k < 2; k++)
        begin
            pa = {c, k[0]};
            if (!pal_known[pa])
                send_request(CMD_PALETTE_WRITE, {7'($urandom), pa}, 8'($urandom),
                             10'($urandom), 10'($urandom), BY_MODEL, '0);
        end
    endtask

    // one request through the slave side, predicted when accepted
    task automatic send_request(input logic [1:0] cmd, input logic [15:0] addr,
                                input logic [7:0] data, input logic [9:0] lx,
                                input logic [9:0] ly, input check_t chk, input pixel_t want);
        pixel_t px;
        bit     hit;
        if (cmd == CMD_PLOT)
            fill_for_plot(lx, ly);
        while (!calm && $urandom_range(0, 99) < 23)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, ly, lx, data, addr};
        do
            @(posedge clk);
        while (!s_tready);
        hit = render_pixel(cmd, addr, data, lx, ly, px);
        case (chk)
            BY_MODEL: if (hit) pending_pixels.push_back(px);
            PIXEL_AT: pending_pixels.push_back(want);
            default:  ;
        endcase
        if (cmd == CMD_PLOT)
            plots_done++;
        else if (cmd != CMD_UNUSED)
            writes_done++;
        if (cmd != CMD_UNUSED)
            reqs_done++;
    endtask

    task automatic load_regs(input regs_t r);
        wait_idle();
        write_reg(REG_ORIGIN_X, 16'(r.org_x) | reg_junk(REG_ORIGIN_X));
        write_reg(REG_ORIGIN_Y, 16'(r.org_y) | reg_junk(REG_ORIGIN_Y));
        write_reg(REG_FLIP_MODE, 16'(r.flip) | reg_junk(REG_FLIP_MODE));
        write_reg(REG_BPP, 16'(r.bpp) | reg_junk(REG_BPP));
        write_reg(REG_PALETTE_BASE, 16'(r.pal_base) | reg_junk(REG_PALETTE_BASE));
        write_reg(REG_IMAGE_WIDTH, 16'(r.width) | reg_junk(REG_IMAGE_WIDTH));
        write_reg(REG_IMAGE_HEIGHT, 16'(r.height) | reg_junk(REG_IMAGE_HEIGHT));
        write_reg(REG_TILE_BASE, r.tile_base);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [10:0] pick_size();
        case ($urandom_range(0, 3))
            0:       return 11'($urandom_range(1, 16));
            1:       return 11'($urandom_range(1, 64));
            2:       return 11'(8 * $urandom_range(1, 32));
            default: return 11'($urandom_range(1, 1024));
        endcase
    endfunction

    // first setting all lows, second all highs, then mixed
    function automatic regs_t pick_regs(input int phase);
        regs_t r;
        int    pick;
        if (phase == 0)
        begin
            r.org_x = 0; r.org_y = 0; r.flip = 0; r.bpp = BPP_2;
            r.pal_base = 0; r.width = 1; r.height = 1; r.tile_base = 0;
        end
        else if (phase == 1)
        begin
            r.org_x = 511; r.org_y = 255; r.flip = 3; r.bpp = BPP_8;
            r.pal_base = 255; r.width = 1024; r.height = 1024; r.tile_base = 16'hffff;
        end
        else
        begin
            r.org_x = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 200));
            r.org_y = 8'($urandom);
            r.flip = 2'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 3)
                r.bpp = BPP_2;
            else if (pick < 6)
                r.bpp = BPP_4;
            else if (pick < 8)
                r.bpp = BPP_8;
            else
                r.bpp = 4'($urandom);
            r.pal_base = 8'($urandom);
            r.width = pick_size();
            r.height = pick_size();
            r.tile_base = 16'($urandom);
        end
        return r;
    endfunction

    // mostly in-image plots, some stray plots, store writes and unused commands
    task automatic random_request();
        int         r;
        logic [9:0] lx;
        logic [9:0] ly;
        r = $urandom_range(0, 99);
        lx = 10'($urandom);
        ly = 10'($urandom);
        if (r < 60)
        begin
            lx = 10'($urandom_range(0, int'(regs.width) - 1));
            ly = 10'($urandom_range(0, int'(regs.height) - 1));
        end
        if (r < 72)
            send_request(CMD_PLOT, 16'($urandom), 8'($urandom), lx, ly, BY_MODEL, '0);
        else if (r < 84)
            send_request(CMD_VIDEO_WRITE, 16'($urandom), 8'($urandom), lx, ly, BY_MODEL, '0);
        else if (r < 94)
            send_request(CMD_PALETTE_WRITE, 16'($urandom), 8'($urandom), lx, ly,
                         BY_MODEL, '0);
        else
            send_request(CMD_UNUSED, 16'($urandom), 8'($urandom), lx, ly, NO_PIXEL, '0);
    endtask

    function automatic step_t reg_step(input logic [2:0] idx, input logic [15:0] val);
        step_t s;
        s = '0;
        s.kind = STEP_REG;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic step_t req_step(input logic [1:0] cmd, input logic [15:0] addr,
                                       input logic [7:0] data, input logic [9:0] lx,
                                       input logic [9:0] ly, input check_t chk);
        step_t s;
        s = '0;
        s.kind = STEP_REQ;
        s.chk = chk;
        s.cmd = cmd;
        s.addr = addr;
        s.data = data;
        s.lx = lx;
        s.ly = ly;
        return s;
    endfunction

    function automatic step_t pix_step(input logic [9:0] lx, input logic [9:0] ly,
                                       input logic [7:0] x, input logic [7:0] y,
                                       input logic [15:0] color);
        step_t s;
        s = req_step(CMD_PLOT, 16'h0, 8'h0, lx, ly, PIXEL_AT);
        s.want.x = x;
        s.want.y = y;
        s.want.color = color;
        return s;
    endfunction

    initial
    begin : stimulus
        step_t plan [$];
        bit    in_cfg;
        int    start;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_VIDEO_WRITE;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_ORIGIN_X;
        cfg_data  <= '0;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        regs = '0;
        regs.bpp = RST_BPP;
        regs.width = RST_IMAGE_WIDTH;
        regs.height = RST_IMAGE_HEIGHT;

        // one pixel in plane 0 at x 0 and 1, color 1 in the palette
        plan.push_back(req_step(CMD_VIDEO_WRITE, 16'd0, 8'hc0, 10'd0, 10'd0, BY_MODEL));
        plan.push_back(req_step(CMD_VIDEO_WRITE, 16'd1, 8'h00, 10'd0, 10'd0, BY_MODEL));
        plan.push_back(req_step(CMD_VIDEO_WRITE, 16'd16, 8'h00, 10'd0, 10'd0, BY_MODEL));
        plan.push_back(req_step(CMD_VIDEO_WRITE, 16'd17, 8'h00, 10'd0, 10'd0, BY_MODEL));
        plan.push_back(req_step(CMD_PALETTE_WRITE, 16'd2, 8'h34, 10'd0, 10'd0, BY_MODEL));
        plan.push_back(req_step(CMD_PALETTE_WRITE, 16'd3, 8'h12, 10'd0, 10'd0, BY_MODEL));
        plan.push_back(pix_step(10'd0, 10'd0, 8'd0, 8'd0, 16'h1234));
        // outside the image, transparent, unused command
        plan.push_back(req_step(CMD_PLOT, 16'd0, 8'd0, 10'd8, 10'd0, NO_PIXEL));
        plan.push_back(req_step(CMD_PLOT, 16'd0, 8'd0, 10'd0, 10'd8, NO_PIXEL));
        plan.push_back(req_step(CMD_PLOT, 16'd0, 8'd0, 10'd2, 10'd0, NO_PIXEL));
        plan.push_back(req_step(CMD_UNUSED, 16'hffff, 8'hff, 10'h3ff, 10'h3ff, NO_PIXEL));
        // top store addresses, palette address wraps
        plan.push_back(req_step(CMD_VIDEO_WRITE, 16'hffff, 8'hff, 10'd0, 10'd0, BY_MODEL));
        plan.push_back(req_step(CMD_PALETTE_WRITE, 16'hffff, 8'hff, 10'd0, 10'd0, BY_MODEL));
        // last visible column, then past the edge, then wrap to column 0
        plan.push_back(reg_step(REG_ORIGIN_X, 16'd255));
        plan.push_back(pix_step(10'd0, 10'd0, 8'd255, 8'd0, 16'h1234));
        plan.push_back(reg_step(REG_ORIGIN_X, 16'd256));
        plan.push_back(req_step(CMD_PLOT, 16'd0, 8'd0, 10'd0, 10'd0, NO_PIXEL));
        plan.push_back(reg_step(REG_ORIGIN_X, 16'd511));
        plan.push_back(reg_step(REG_ORIGIN_Y, 16'd255));
        plan.push_back(pix_step(10'd1, 10'd0, 8'd0, 8'd255, 16'h1234));
        // unsupported depth
        plan.push_back(reg_step(REG_BPP, 16'd5));
        plan.push_back(req_step(CMD_PLOT, 16'd0, 8'd0, 10'd0, 10'd0, NO_PIXEL));
        // 2 planes, both flips, base wrap, tile address wrap
        plan.push_back(reg_step(REG_BPP, 16'(BPP_2)));
        plan.push_back(reg_step(REG_FLIP_MODE, 16'd3));
        plan.push_back(reg_step(REG_PALETTE_BASE, 16'd255));
        plan.push_back(reg_step(REG_TILE_BASE, 16'hffff));
        plan.push_back(req_step(CMD_PLOT, 16'd0, 8'd0, 10'd7, 10'd7, BY_MODEL));
        // 8 planes on the largest image, flipped and not
        plan.push_back(reg_step(REG_BPP, 16'(BPP_8)));
        plan.push_back(reg_step(REG_IMAGE_WIDTH, 16'd1024));
        plan.push_back(reg_step(REG_IMAGE_HEIGHT, 16'd1024));
        plan.push_back(reg_step(REG_ORIGIN_X, 16'd1));
        plan.push_back(req_step(CMD_PLOT, 16'd0, 8'd0, 10'd1023, 10'd1023, BY_MODEL));
        plan.push_back(reg_step(REG_FLIP_MODE, 16'd0));
        plan.push_back(req_step(CMD_PLOT, 16'd0, 8'd0, 10'd1023, 10'd1023, BY_MODEL));
        // zero width draws nothing
        plan.push_back(reg_step(REG_IMAGE_WIDTH, 16'd0));
        plan.push_back(req_step(CMD_PLOT, 16'd0, 8'd0, 10'd0, 10'd0, NO_PIXEL));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        in_cfg = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_REG)
            begin
                if (!in_cfg)
                    wait_idle();
                in_cfg = 1'b1;
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                if (in_cfg)
                    cfg_we <= 1'b0;
                in_cfg = 1'b0;
                send_request(plan[i].cmd, plan[i].addr, plan[i].data, plan[i].lx,
                             plan[i].ly, plan[i].chk, plan[i].want);
            end
        end
        if (in_cfg)
            cfg_we <= 1'b0;

        // random phases, one register setting each
        for (int phase = 0; phase < PHASES; phase++)
        begin
            load_regs(pick_regs(phase));
            calm = (phase == CALM_PHASE);
            start = reqs_done;
            while (reqs_done - start < PHASE_REQS)
                random_request();
        end
        calm = 1'b0;

        wait_idle();
        $display("requests accepted: %0d (%0d plots, %0d store writes), pixels checked: %0d",
                 reqs_done, plots_done, writes_done, pixels_seen);
        $display("register writes: %0d over %0d settings, both range ends included",
                 reg_writes, PHASES + 1);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
